>>> rtl/wiat_pkg.sv
package wiat_pkg;

  localparam int unsigned MaxResults = 16;
  localparam int unsigned ResCntW = 5;

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_CLEAR  = 3'd2,
    ACT_TICK   = 3'd3,
    ACT_FINISH = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    RK_STATUS   = 2'd0,
    RK_DISPATCH = 2'd1,
    RK_CANCEL   = 2'd2
  } result_kind_e;

  localparam logic [1:0] CmdCustom = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_EVAL,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] entry_key;
    logic        entry_enabled;
    logic        entry_mode;
    logic [6:0]  day_mask;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] interval_minutes;
    logic [15:0] run_seconds;
    logic [1:0]  job_kind;
    logic [31:0] now_seconds;
    logic [2:0]  weekday;
  } item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        status;
    logic [31:0] job_key;
    logic [1:0]  command_type;
    logic [15:0] job_duration;
    logic [31:0] dispatch_time;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [31:0] key;
    logic        enabled;
    logic        mode;
    logic [6:0]  days;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [1:0]  kind;
    logic [15:0] interval;
    logic [15:0] duration;
    logic [31:0] last_run;
    logic        running;
  } entry_t;

endpackage

>>> rtl/wiat_if.sv
interface wiat_in_if;
  logic valid;
  logic ready;
  wiat_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wiat_out_if;
  logic valid;
  logic ready;
  wiat_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/wiat_ram.sv
module wiat_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  wiat_pkg::entry_t     wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output wiat_pkg::entry_t     rdata_o
);
  import wiat_pkg::*;

  entry_t mem [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/weekday_interval_alarm_table.sv
// Ordered alarm table of TABLE_ENTRIES entries held in one single-port-write,
// registered-read memory. Items are taken one at a time: each item walks the
// table one entry at a time (read, then evaluate and write back); add and
// finish stop at a match, undefined actions skip the walk, and the walk stalls
// while the result side holds a new result back. Remove shifts later entries
// down the same walk. Results of an item leave through one output register
// in table order, the final one with last; at most 16 are reported per item.
module weekday_interval_alarm_table #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  wiat_in_if.sink    item_i,
  wiat_out_if.source result_o
);
  import wiat_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] Full = CW'(TABLE_ENTRIES);

  state_e state_q, state_d;
  item_t in_q;
  logic [CW-1:0] cnt_q, cnt_d, ptr_q, ptr_d;
  logic shift_q, shift_d, full_q, full_d;
  result_t pend_q, pend_d, out_q, out_new;
  logic pendv_q, pendv_d, outv_q, out_load;
  logic [ResCntW-1:0] n_q, n_d;

  logic we, re;
  logic [IW-1:0] waddr, raddr;
  entry_t wdata, rd;

  wiat_ram #(.Depth(TABLE_ENTRIES), .AddrW(IW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(re), .raddr_i(raddr), .rdata_o(rd)
  );

  logic out_free;
  assign out_free = !outv_q || result_o.ready;
  assign item_i.ready = (state_q == S_IDLE);
  assign result_o.valid = outv_q;
  assign result_o.data = out_q;

  logic match, gen, gen_eff, stall, due;
  result_t gen_res, stat_res;
  logic [32:0] diff, iv60;

  always_comb begin
    match = (rd.key == in_q.entry_key);
    diff = {1'b0, in_q.now_seconds} - {1'b0, rd.last_run};
    iv60 = ({17'd0, rd.interval} << 6) - ({17'd0, rd.interval} << 2);
    if (!rd.mode) begin
      due = (in_q.weekday != 3'd7) && rd.days[in_q.weekday] &&
            (rd.hour == in_q.hour) && (rd.minute == in_q.minute) &&
            ($signed(diff) > 33'sd60);
    end else begin
      due = (rd.last_run == 32'd0) || ($signed(diff) >= $signed(iv60));
    end
    stat_res = '0;
    stat_res.result_kind = RK_STATUS;
    stat_res.status = full_q;
    stat_res.last = 1'b1;
  end

  always_comb begin
    state_d = state_q;
    ptr_d = ptr_q;
    cnt_d = cnt_q;
    shift_d = shift_q;
    full_d = full_q;
    pend_d = pend_q;
    pendv_d = pendv_q;
    n_d = n_q;
    we = 1'b0;
    waddr = ptr_q[IW-1:0];
    wdata = rd;
    re = 1'b0;
    raddr = ptr_q[IW-1:0];
    out_load = 1'b0;
    out_new = pend_q;
    gen = 1'b0;
    gen_eff = 1'b0;
    stall = 1'b0;
    gen_res = '0;

    unique case (state_q)
      S_IDLE: begin
        if (item_i.valid) begin
          ptr_d = '0;
          shift_d = 1'b0;
          full_d = 1'b0;
          n_d = '0;
          pendv_d = 1'b0;
          case (item_i.data.action) inside
            ACT_ADD, ACT_REMOVE, ACT_CLEAR, ACT_TICK, ACT_FINISH: state_d = S_RD;
            default: state_d = S_FIN;
          endcase
        end
      end
      S_RD: begin
        if (ptr_q >= cnt_q) begin
          state_d = S_FIN;
          case (in_q.action)
            ACT_ADD: begin
              if (cnt_q >= Full) begin
                full_d = 1'b1;
              end else begin
                we = 1'b1;
                waddr = cnt_q[IW-1:0];
                wdata.key = in_q.entry_key;
                wdata.enabled = in_q.entry_enabled;
                wdata.mode = in_q.entry_mode;
                wdata.days = in_q.day_mask;
                wdata.hour = in_q.hour;
                wdata.minute = in_q.minute;
                wdata.kind = in_q.job_kind;
                wdata.interval = in_q.interval_minutes;
                wdata.duration = in_q.run_seconds;
                wdata.last_run = '0;
                wdata.running = 1'b0;
                cnt_d = cnt_q + 1'b1;
              end
            end
            ACT_REMOVE: if (shift_q) cnt_d = cnt_q - 1'b1;
            ACT_CLEAR: cnt_d = '0;
            default: ;
          endcase
        end else begin
          re = 1'b1;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        case (in_q.action)
          ACT_REMOVE: if (!shift_q && match && rd.running) gen = 1'b1;
          ACT_CLEAR: gen = rd.running;
          ACT_TICK: gen = rd.enabled && !rd.running && due;
          default: ;
        endcase
        gen_res.result_kind = (in_q.action == ACT_TICK) ? RK_DISPATCH : RK_CANCEL;
        gen_res.job_key = (in_q.action == ACT_REMOVE) ? in_q.entry_key : rd.key;
        if (in_q.action == ACT_TICK) begin
          gen_res.command_type = (rd.kind > CmdCustom) ? CmdCustom : rd.kind;
          gen_res.job_duration = rd.duration;
          gen_res.dispatch_time = in_q.now_seconds;
        end
        gen_eff = gen && (n_q < ResCntW'(MaxResults));
        stall = gen_eff && pendv_q && !out_free;
        if (!stall) begin
          ptr_d = ptr_q + 1'b1;
          state_d = S_RD;
          case (in_q.action)
            ACT_ADD: begin
              if (match) begin
                we = 1'b1;
                wdata.enabled = in_q.entry_enabled;
                wdata.mode = in_q.entry_mode;
                wdata.days = in_q.day_mask;
                wdata.hour = in_q.hour;
                wdata.minute = in_q.minute;
                wdata.kind = in_q.job_kind;
                wdata.interval = in_q.interval_minutes;
                wdata.duration = in_q.run_seconds;
                state_d = S_FIN;
              end
            end
            ACT_FINISH: begin
              if (match) begin
                we = 1'b1;
                wdata.running = 1'b0;
                state_d = S_FIN;
              end
            end
            ACT_REMOVE: begin
              if (shift_q) begin
                we = 1'b1;
                waddr = IW'(ptr_q - 1'b1);
              end else if (match) begin
                shift_d = 1'b1;
              end
            end
            ACT_TICK: begin
              if (gen) begin
                we = 1'b1;
                wdata.last_run = in_q.now_seconds;
                wdata.running = 1'b1;
              end
            end
            default: ;
          endcase
          if (gen_eff) begin
            if (pendv_q) begin
              out_load = 1'b1;
              out_new = pend_q;
              out_new.last = 1'b0;
            end
            pend_d = gen_res;
            pendv_d = 1'b1;
            n_d = n_q + 1'b1;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          out_new = pendv_q ? pend_q : stat_res;
          out_new.last = 1'b1;
          pendv_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      ptr_q <= '0;
      shift_q <= 1'b0;
      full_q <= 1'b0;
      pendv_q <= 1'b0;
      n_q <= '0;
      outv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
      shift_q <= shift_d;
      full_q <= full_d;
      pendv_q <= pendv_d;
      n_q <= n_d;
      if (out_load) begin
        outv_q <= 1'b1;
      end else if (result_o.ready) begin
        outv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (out_load) begin
      out_q <= out_new;
    end
    if (item_i.valid && item_i.ready) begin
      in_q <= item_i.data;
    end
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import wiat_pkg::*;

  localparam int unsigned Entries = 16;
  localparam int unsigned RandomItems = 380;
  localparam int unsigned CycleLimit = 1000000;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wiat_in_if  item_if ();
  wiat_out_if res_if ();

  weekday_interval_alarm_table #(.TABLE_ENTRIES(Entries)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(res_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  entry_t  alarm_tbl[Entries];
  int      alarm_cnt;
  result_t pending_results[$];
  row_t    rows[$];
  int      err_cnt;
  int      cycle_cnt;
  int      send_idle_pct;
  int      recv_stall_pct;
  logic [31:0] clock_now;
  logic [31:0] key_pool[20];

  function automatic result_t status_res(logic st);
    result_t r;
    r = '0;
    r.result_kind = RK_STATUS;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int find_alarm(logic [31:0] k);
    for (int i = 0; i < alarm_cnt; i++) begin
      if (alarm_tbl[i].key == k) return i;
    end
    return -1;
  endfunction

  // updates the table and returns the results the item causes
  function automatic void run_alarm_table(item_t it, ref result_t rq[$]);
    result_t r;
    int idx;
    longint since;
    bit due;
    rq = {};
    r = '0;
    case (it.action)
      ACT_ADD: begin
        idx = find_alarm(it.entry_key);
        if (idx < 0 && alarm_cnt >= Entries) begin
          rq.push_back(status_res(1'b1));
        end else begin
          if (idx < 0) begin
            idx = alarm_cnt;
            alarm_cnt++;
            alarm_tbl[idx].key = it.entry_key;
            alarm_tbl[idx].last_run = '0;
            alarm_tbl[idx].running = 1'b0;
          end
          alarm_tbl[idx].enabled = it.entry_enabled;
          alarm_tbl[idx].mode = it.entry_mode;
          alarm_tbl[idx].days = it.day_mask;
          alarm_tbl[idx].hour = it.hour;
          alarm_tbl[idx].minute = it.minute;
          alarm_tbl[idx].kind = it.job_kind;
          alarm_tbl[idx].interval = it.interval_minutes;
          alarm_tbl[idx].duration = it.run_seconds;
          rq.push_back(status_res(1'b0));
        end
      end
      ACT_REMOVE: begin
        idx = find_alarm(it.entry_key);
        if (idx >= 0) begin
          if (alarm_tbl[idx].running) begin
            r.result_kind = RK_CANCEL;
            r.job_key = it.entry_key;
            rq.push_back(r);
          end
          for (int i = idx; i + 1 < alarm_cnt; i++) alarm_tbl[i] = alarm_tbl[i + 1];
          alarm_cnt--;
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < alarm_cnt; i++) begin
          if (alarm_tbl[i].running) begin
            r = '0;
            r.result_kind = RK_CANCEL;
            r.job_key = alarm_tbl[i].key;
            rq.push_back(r);
          end
          alarm_tbl[i].running = 1'b0;
        end
        alarm_cnt = 0;
      end
      ACT_TICK: begin
        for (int i = 0; i < alarm_cnt; i++) begin
          if (alarm_tbl[i].enabled && !alarm_tbl[i].running) begin
            since = longint'(it.now_seconds) - longint'(alarm_tbl[i].last_run);
            if (!alarm_tbl[i].mode) begin
              due = it.weekday < 7 && alarm_tbl[i].days[it.weekday] &&
                    alarm_tbl[i].hour == it.hour && alarm_tbl[i].minute == it.minute &&
                    since > 60;
            end else begin
              due = alarm_tbl[i].last_run == 0 ||
                    since >= longint'(alarm_tbl[i].interval) * 60;
            end
            if (due && rq.size() < MaxResults) begin
              r = '0;
              r.result_kind = RK_DISPATCH;
              r.job_key = alarm_tbl[i].key;
              r.command_type = alarm_tbl[i].kind > 2 ? CmdCustom : alarm_tbl[i].kind;
              r.job_duration = alarm_tbl[i].duration;
              r.dispatch_time = it.now_seconds;
              rq.push_back(r);
            end
            if (due) begin
              alarm_tbl[i].last_run = it.now_seconds;
              alarm_tbl[i].running = 1'b1;
            end
          end
        end
      end
      ACT_FINISH: begin
        idx = find_alarm(it.entry_key);
        if (idx >= 0) alarm_tbl[idx].running = 1'b0;
      end
      default: ;
    endcase
    if (rq.size() == 0) rq.push_back(status_res(1'b0));
    rq[rq.size() - 1].last = 1'b1;
  endfunction

  function automatic item_t mk_item(logic [2:0] act, logic [31:0] k = '0,
                                    logic en = 1'b1, logic md = 1'b0,
                                    logic [6:0] dm = 7'h7f, logic [4:0] hr = '0,
                                    logic [5:0] mn = '0, logic [15:0] iv = '0,
                                    logic [15:0] dur = '0, logic [1:0] jk = '0,
                                    logic [31:0] now = '0, logic [2:0] wd = '0);
    item_t it;
    it.action = act;
    it.entry_key = k;
    it.entry_enabled = en;
    it.entry_mode = md;
    it.day_mask = dm;
    it.hour = hr;
    it.minute = mn;
    it.interval_minutes = iv;
    it.run_seconds = dur;
    it.job_kind = jk;
    it.now_seconds = now;
    it.weekday = wd;
    return it;
  endfunction

  function automatic void add_row(item_t it, bit typed = 1'b0, result_t res = '0);
    row_t rw;
    rw.it = it;
    rw.typed = typed;
    rw.res = res;
    rows.push_back(rw);
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int pick;
    int sel;
    it = item_t'({$urandom, $urandom, $urandom, $urandom});
    pick = $urandom_range(99);
    it.entry_key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(19)];
    if (alarm_cnt > 0 && $urandom_range(1)) begin
      it.entry_key = alarm_tbl[$urandom_range(alarm_cnt - 1)].key;
    end
    it.job_kind = 2'($urandom_range(3));
    if (pick < 35) begin
      it.action = ACT_ADD;
      if ($urandom_range(1)) it.day_mask = 7'h7f;
      if ($urandom_range(3) != 0) it.interval_minutes = 16'($urandom_range(4));
      it.hour = 5'(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(2));
      it.minute = 6'(($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(2));
      if ($urandom_range(5) != 0) it.entry_enabled = 1'b1;
    end else if (pick < 65) begin
      it.action = ACT_TICK;
      clock_now = clock_now + $urandom_range(30, 400);
      it.now_seconds = ($urandom_range(19) == 0) ? $urandom : clock_now;
      it.weekday = 3'($urandom_range(7));
      if (alarm_cnt > 0 && $urandom_range(2) != 0) begin
        sel = $urandom_range(alarm_cnt - 1);
        it.hour = alarm_tbl[sel].hour;
        it.minute = alarm_tbl[sel].minute;
      end
    end else if (pick < 83) begin
      it.action = ACT_FINISH;
    end else if (pick < 95) begin
      it.action = ACT_REMOVE;
    end else if (pick < 98) begin
      it.action = ACT_CLEAR;
    end else begin
      it.action = 3'($urandom_range(5, 7));
    end
    return it;
  endfunction

  task automatic send_item(item_t it, bit typed, result_t res);
    result_t rq[$];
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      if (!lowered) item_if.valid <= 1'b0;
      lowered = 1'b1;
      @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.data <= it;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    run_alarm_table(it, rq);
    if (typed) pending_results.push_back(res);
    else foreach (rq[i]) pending_results.push_back(rq[i]);
  endtask

  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %p", got);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got.result_kind !== want.result_kind) begin
          $error("result_kind exp %0d got %0d", want.result_kind, got.result_kind);
          err_cnt++;
        end
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status);
          err_cnt++;
        end
        if (got.job_key !== want.job_key) begin
          $error("job_key exp %0h got %0h", want.job_key, got.job_key);
          err_cnt++;
        end
        if (got.command_type !== want.command_type) begin
          $error("command_type exp %0d got %0d", want.command_type, got.command_type);
          err_cnt++;
        end
        if (got.job_duration !== want.job_duration) begin
          $error("job_duration exp %0d got %0d", want.job_duration, got.job_duration);
          err_cnt++;
        end
        if (got.dispatch_time !== want.dispatch_time) begin
          $error("dispatch_time exp %0h got %0h", want.dispatch_time, got.dispatch_time);
          err_cnt++;
        end
        if (got.last !== want.last) begin
          $error("last exp %0d got %0d", want.last, got.last);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int waited;
    err_cnt = 0;
    cycle_cnt = 0;
    alarm_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    clock_now = 32'd1000000;
    item_if.valid = 1'b0;
    item_if.data = '0;
    res_if.ready = 1'b0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;

    // empty table, undefined actions, unknown keys
    add_row(mk_item(ACT_TICK, .now(32'd500)), 1'b1, status_res(1'b0));
    add_row(mk_item(3'd5), 1'b1, status_res(1'b0));
    add_row(mk_item(3'd7, '1), 1'b1, status_res(1'b0));
    add_row(mk_item(ACT_REMOVE, 32'h1234), 1'b1, status_res(1'b0));
    add_row(mk_item(ACT_FINISH, 32'h1234), 1'b1, status_res(1'b0));
    // daily at the extremes, interval never run
    add_row(mk_item(ACT_ADD, '0, 1'b1, 1'b0, 7'h7f, 5'd23, 6'd59, '1, '1, 2'd3),
            1'b1, status_res(1'b0));
    add_row(mk_item(ACT_ADD, '1, 1'b1, 1'b1, 7'h00, 5'd0, 6'd0, 16'd0, 16'd7, 2'd1),
            1'b1, status_res(1'b0));
    add_row(mk_item(ACT_ADD, 32'h5, 1'b1, 1'b1, 7'h00, 5'd0, 6'd0, 16'd1, 16'd9, 2'd2),
            1'b1, status_res(1'b0));
    add_row(mk_item(ACT_TICK, .hr(5'd23), .mn(6'd59), .now(32'd0), .wd(3'd6)));
    add_row(mk_item(ACT_TICK, .hr(5'd23), .mn(6'd59), .now(32'd61), .wd(3'd0)));
    add_row(mk_item(ACT_FINISH, '1));
    add_row(mk_item(ACT_TICK, .hr(5'd23), .mn(6'd59), .now(32'd120), .wd(3'd7)));
    add_row(mk_item(ACT_REMOVE, 32'h5));
    add_row(mk_item(ACT_ADD, '0, 1'b1, 1'b0, 7'h01, 5'd23, 6'd59, 16'd0, 16'd3, 2'd0),
            1'b1, status_res(1'b0));
    add_row(mk_item(ACT_FINISH, '0));
    add_row(mk_item(ACT_TICK, .hr(5'd23), .mn(6'd59), .now('1), .wd(3'd0)));
    add_row(mk_item(ACT_TICK, .hr(5'd23), .mn(6'd59), .now(32'd10), .wd(3'd0)));
    add_row(mk_item(ACT_CLEAR));
    add_row(mk_item(ACT_CLEAR), 1'b1, status_res(1'b0));
    for (int i = 0; i < Entries; i++) begin
      add_row(mk_item(ACT_ADD, 32'h100 + i, 1'b1, 1'b1, 7'h00, 5'd0, 6'd0, 16'd0,
                      16'(i), 2'(i)),
              1'b1, status_res(1'b0));
    end
    add_row(mk_item(ACT_ADD, 32'h999), 1'b1, status_res(1'b1));
    add_row(mk_item(ACT_TICK, .now(32'd300)));
    add_row(mk_item(ACT_CLEAR));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].res);

    for (int n = 0; n < RandomItems; n++) begin
      case (n * 4 / RandomItems)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      send_item(rand_item(), 1'b0, '0);
    end
    item_if.valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/wiat_pkg.sv
rtl/wiat_if.sv
rtl/wiat_ram.sv
rtl/weekday_interval_alarm_table.sv
verif/tb_top.sv
